/* rtl/core/xst_pkg.sv */
// Package for the XML byte tokenizer: character codes, token kinds,
// the mode-flag record and the token record. No dependencies.
`timescale 1ns / 1ps

package xst_pkg;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUES  = 8'h3F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// Depth of the token queue; must be at least two.
	localparam int TOK_DEPTH = 4;

	typedef enum logic [3:0] {
		K_TEXT_CHAR     = 4'd0,
		K_TEXT_END      = 4'd1,
		K_TAG_OPEN      = 4'd2,
		K_NAME_CHAR     = 4'd3,
		K_ATTR_START    = 4'd4,
		K_ATTR_NAME     = 4'd5,
		K_ATTR_VALUE    = 4'd6,
		K_BEGIN         = 4'd7,
		K_END           = 4'd8,
		K_COMMENT_START = 4'd9,
		K_COMMENT_CHAR  = 4'd10,
		K_COMMENT_END   = 4'd11
	} kind_t;

	typedef struct packed {
		logic reading_tag;
		logic opening_tag;
		logic closing_tag;
		logic in_name;
		logic in_comment_body;
		logic in_text;
		logic in_decl;
		logic in_attr_list;
		logic in_quoted_value;
		logic text_pending;
		logic [7:0] previous_byte;
	} flags_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] tbyte;
		logic       last;
	} token_t;

	// Tokens produced by one byte and how many of them are valid (0 to 2).
	typedef struct packed {
		token_t     t0;
		token_t     t1;
		logic [1:0] count;
	} tok_pair_t;

endpackage

/* rtl/core/xst_step.sv */
// Per-byte decode: mode flags and previous byte, and the 0..2 tokens a byte makes.
// Depends on xst_pkg.
`timescale 1ns / 1ps

module xst_step
	import xst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] ch,
	output tok_pair_t  toks
);

	flags_t cur_q;
	flags_t nxt;
	logic   begin_f;

	always_comb begin
		nxt     = cur_q;
		toks    = '0;
		begin_f = 1'b0;
		if (ch != CH_TAB && ch != CH_NL) begin
			if (ch == CH_LT) begin
				nxt.in_text = 1'b0;
				if (cur_q.text_pending) begin
					toks.t0.kind = K_TEXT_END;
					toks.t1.kind = K_TAG_OPEN;
					toks.count   = 2'd2;
				end else begin
					toks.t0.kind = K_TAG_OPEN;
					toks.count   = 2'd1;
				end
				nxt.text_pending = 1'b0;
				nxt.opening_tag  = 1'b1;
				nxt.reading_tag  = 1'b1;
				nxt.in_name      = 1'b1;
				nxt.in_attr_list = 1'b0;
				nxt.closing_tag  = 1'b0;
			end else if (ch == CH_BANG && cur_q.in_name) begin
				nxt.in_comment_body = 1'b1;
				toks.t0.kind = K_COMMENT_START;
				toks.count   = 2'd1;
			end else if (ch == CH_QUES && cur_q.in_name) begin
				nxt.in_decl = 1'b1;
			end else if (ch == CH_SLASH && (cur_q.in_name ||
					(cur_q.in_attr_list && !cur_q.in_quoted_value))) begin
				nxt.opening_tag = 1'b0;
				nxt.closing_tag = 1'b1;
			end else if (ch == CH_GT) begin
				nxt.in_text = 1'b1;
				if (cur_q.in_comment_body) begin
					nxt.in_comment_body = 1'b0;
					toks.t0.kind = K_COMMENT_END;
					toks.count   = 2'd1;
				end else if (cur_q.in_decl) begin
					nxt.in_decl = 1'b0;
				end else begin
					begin_f = cur_q.opening_tag || cur_q.previous_byte == CH_SLASH;
					if (begin_f) begin
						toks.t0.kind    = K_BEGIN;
						toks.count      = 2'd1;
						nxt.opening_tag = 1'b0;
					end
					if (cur_q.closing_tag) begin
						if (begin_f) begin
							toks.t1.kind = K_END;
							toks.count   = 2'd2;
						end else begin
							toks.t0.kind = K_END;
							toks.count   = 2'd1;
						end
					end
					nxt.in_attr_list = 1'b0;
					nxt.in_name      = 1'b0;
					nxt.closing_tag  = 1'b0;
					nxt.reading_tag  = 1'b0;
				end
			end else if (!cur_q.in_comment_body && !cur_q.in_decl) begin
				if (cur_q.reading_tag) begin
					if (cur_q.in_name) begin
						if (ch == CH_SP) begin
							nxt.in_name      = 1'b0;
							nxt.in_attr_list = 1'b1;
							toks.t0.kind     = K_ATTR_START;
						end else begin
							toks.t0.kind  = K_NAME_CHAR;
							toks.t0.tbyte = ch;
						end
						toks.count = 2'd1;
					end else if (cur_q.in_attr_list && cur_q.opening_tag) begin
						if (!cur_q.in_quoted_value && ch == CH_SP) begin
							toks.t0.kind = K_ATTR_START;
							toks.count   = 2'd1;
						end else if (ch == CH_QUOTE) begin
							nxt.in_quoted_value = !cur_q.in_quoted_value;
						end else if (cur_q.in_quoted_value) begin
							toks.t0.kind  = K_ATTR_VALUE;
							toks.t0.tbyte = ch;
							toks.count    = 2'd1;
						end else if (ch != CH_EQ) begin
							toks.t0.kind  = K_ATTR_NAME;
							toks.t0.tbyte = ch;
							toks.count    = 2'd1;
						end
					end
				end else if (cur_q.in_text) begin
					// collapse a space after space, newline or '<'
					if (ch != CH_SP || (cur_q.previous_byte != CH_SP &&
							cur_q.previous_byte != CH_NL &&
							cur_q.previous_byte != CH_LT)) begin
						toks.t0.kind     = K_TEXT_CHAR;
						toks.t0.tbyte    = ch;
						toks.count       = 2'd1;
						nxt.text_pending = 1'b1;
					end
				end
			end else if (cur_q.in_comment_body && ch != CH_DASH) begin
				toks.t0.kind  = K_COMMENT_CHAR;
				toks.t0.tbyte = ch;
				toks.count    = 2'd1;
			end
		end
		nxt.previous_byte = ch;
		toks.t0.last = (toks.count == 2'd1);
		toks.t1.last = (toks.count == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (advance) begin
			cur_q <= nxt;
		end
	end

endmodule

/* rtl/core/xst_tok_fifo.sv */
// Small token queue: takes up to two tokens a cycle, hands out one while rd_ready is high.
// Depends on xst_pkg.
`timescale 1ns / 1ps

module xst_tok_fifo
	import xst_pkg::*;
#(
	parameter int DEPTH = TOK_DEPTH
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  tok_pair_t wr_toks,
	output logic      room,
	output logic      rd_valid,
	input  logic      rd_ready,
	output token_t    rd_tok
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	token_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wr_ptr_p1;
	logic [PW-1:0] rd_ptr_p1;
	logic [1:0]    n_in;
	logic          pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1))
			return '0;
		else
			return p + PW'(1);
	endfunction

	assign wr_ptr_p1 = ptr_inc(wr_ptr_q);
	assign rd_ptr_p1 = ptr_inc(rd_ptr_q);
	assign n_in      = wr_en ? wr_toks.count : 2'd0;
	assign room      = (count_q <= CW'(DEPTH - 2));
	assign rd_valid  = (count_q != '0);
	assign pop       = rd_valid && rd_ready;
	assign rd_tok    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			mem_q[wr_ptr_q] <= wr_toks.t0;
		end
		if (n_in == 2'd2) begin
			mem_q[wr_ptr_p1] <= wr_toks.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (n_in == 2'd1) begin
				wr_ptr_q <= wr_ptr_p1;
			end else if (n_in == 2'd2) begin
				wr_ptr_q <= ptr_inc(wr_ptr_p1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_p1;
			end
			count_q <= count_q + CW'(n_in) - CW'(pop);
		end
	end

endmodule

/* rtl/core/xml_sax_tokenizer.sv */
// Top level of the streaming XML tokenizer: input register, byte decode, token queue.
// Depends on xst_pkg, xst_step and xst_tok_fifo.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | char_in[7:0]
//  output   | out_valid / out_ready| token_kind[3:0], token_byte[7:0], last_of_run
//
// One byte is taken per cycle while the queue has room. A byte is held in the
// input register, is decoded against the mode flags and pushes 0, 1 or 2 tokens
// into a DEPTH-entry queue; the queue drains one token per cycle while out_ready
// is high, so bytes that make two tokens (text end + tag open, begin + end) are
// handed out as two separate tokens. Reset clears the flags, the previous byte
// and the queue. A stalled consumer fills the queue; the input register then
// holds and in_ready drops.

module xml_sax_tokenizer
	import xst_pkg::*;
#(
	parameter int DEPTH = TOK_DEPTH
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] token_kind,
	output logic [7:0] token_byte,
	output logic       last_of_run
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       room;
	logic       advance;
	tok_pair_t  toks;
	token_t     head;

	// The byte in the input register moves on once the queue has space
	// for the worst case of two tokens.
	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
		end
	end

	xst_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.ch      (char_s1),
		.toks    (toks)
	);

	xst_tok_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (advance),
		.wr_toks  (toks),
		.room     (room),
		.rd_valid (out_valid),
		.rd_ready (out_ready),
		.rd_tok   (head)
	);

	assign token_kind  = head.kind;
	assign token_byte  = head.tbyte;
	assign last_of_run = head.last;

endmodule

/* tb/xml_sax_tokenizer_tb.sv */
// Self-checking testbench for xml_sax_tokenizer: a scoreboard class predicts the
// token stream from each accepted byte request; tasks drive the input, an always block out_ready.
// Depends on xst_pkg and the xml_sax_tokenizer RTL.
`timescale 1ns / 1ps

import xst_pkg::*;

// Tracks the tokenizer's mode flags and holds the tokens still owed by the block.
class token_scoreboard;
	flags_t mode = '0;
	token_t owed_tokens[$];
	token_t fresh[$];
	int errors = 0;

	function void add_tok(kind_t k, logic [7:0] b);
		token_t t;
		t.kind = k;
		t.tbyte = b;
		t.last = 1'b0;
		if (fresh.size() < 2)
			fresh = {fresh, t};
	endfunction

	// Accepted byte: advance the flags and queue the tokens it should produce.
	function void note_byte(logic [7:0] ch);
		fresh = {};
		if (ch != CH_TAB && ch != CH_NL) begin
			if (ch == CH_LT) begin
				mode.in_text = 1'b0;
				if (mode.text_pending)
					add_tok(K_TEXT_END, 8'h00);
				mode.text_pending = 1'b0;
				add_tok(K_TAG_OPEN, 8'h00);
				mode.opening_tag = 1'b1;
				mode.reading_tag = 1'b1;
				mode.in_name = 1'b1;
				mode.in_attr_list = 1'b0;
				mode.closing_tag = 1'b0;
			end else if (ch == CH_BANG && mode.in_name) begin
				mode.in_comment_body = 1'b1;
				add_tok(K_COMMENT_START, 8'h00);
			end else if (ch == CH_QUES && mode.in_name) begin
				mode.in_decl = 1'b1;
			end else if (ch == CH_SLASH &&
					(mode.in_name || (mode.in_attr_list && !mode.in_quoted_value))) begin
				mode.opening_tag = 1'b0;
				mode.closing_tag = 1'b1;
			end else if (ch == CH_GT) begin
				mode.in_text = 1'b1;
				if (mode.in_comment_body) begin
					mode.in_comment_body = 1'b0;
					add_tok(K_COMMENT_END, 8'h00);
				end else if (mode.in_decl) begin
					mode.in_decl = 1'b0;
				end else begin
					// a '/' just before '>' forces begin, even outside a tag
					if (mode.opening_tag || mode.previous_byte == CH_SLASH) begin
						add_tok(K_BEGIN, 8'h00);
						mode.opening_tag = 1'b0;
					end
					if (mode.closing_tag)
						add_tok(K_END, 8'h00);
					mode.in_attr_list = 1'b0;
					mode.in_name = 1'b0;
					mode.closing_tag = 1'b0;
					mode.reading_tag = 1'b0;
				end
			end else if (!mode.in_comment_body && !mode.in_decl) begin
				if (mode.reading_tag) begin
					if (mode.in_name) begin
						if (ch == CH_SP) begin
							mode.in_name = 1'b0;
							mode.in_attr_list = 1'b1;
							add_tok(K_ATTR_START, 8'h00);
						end else begin
							add_tok(K_NAME_CHAR, ch);
						end
					end else if (mode.in_attr_list && mode.opening_tag) begin
						if (!mode.in_quoted_value && ch == CH_SP)
							add_tok(K_ATTR_START, 8'h00);
						else if (ch == CH_QUOTE)
							mode.in_quoted_value = !mode.in_quoted_value;
						else if (mode.in_quoted_value)
							add_tok(K_ATTR_VALUE, ch);
						else if (ch != CH_EQ)
							add_tok(K_ATTR_NAME, ch);
					end
				end else if (mode.in_text) begin
					// collapse spaces after space, newline or '<'
					if (ch != CH_SP || (mode.previous_byte != CH_SP &&
							mode.previous_byte != CH_NL &&
							mode.previous_byte != CH_LT)) begin
						add_tok(K_TEXT_CHAR, ch);
						mode.text_pending = 1'b1;
					end
				end
			end else if (mode.in_comment_body && ch != CH_DASH) begin
				add_tok(K_COMMENT_CHAR, ch);
			end
		end
		mode.previous_byte = ch;
		if (fresh.size() > 0)
			fresh[fresh.size() - 1].last = 1'b1;
		owed_tokens = {owed_tokens, fresh};
	endfunction

	function void report(string field, logic [7:0] want, logic [7:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endfunction

	// Accepted token: compare with the oldest owed one.
	function void check_token(logic [3:0] kind, logic [7:0] tbyte, logic got_last);
		token_t want;
		if (owed_tokens.size() == 0) begin
			errors++;
			$display("%0t: unexpected token, expected nothing, actual %0h %0h %0b",
				$time, kind, tbyte, got_last);
		end else begin
			want = owed_tokens.pop_front();
			if (kind !== want.kind)
				report("token_kind", 8'(want.kind), 8'(kind));
			if (tbyte !== want.tbyte)
				report("token_byte", want.tbyte, tbyte);
			if (got_last !== want.last)
				report("last_of_run", 8'(want.last), 8'(got_last));
		end
	endfunction
endclass

module xml_sax_tokenizer_tb;

	localparam int STUCK_LIMIT = 2000;   // cycles with no accepted byte and no owed token taken
	localparam int TAIL_CYCLES = 10;     // settle time after the last token

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_in = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] token_kind;
	logic [7:0] token_byte;
	logic       last_of_run;

	token_scoreboard sb = new();

	int stuck_cycles = 0;
	int stall_left = 0;
	int sent_count = 0;
	bit src_gaps = 1'b1;
	bit sink_stalls = 1'b1;
	bit final_stretch = 1'b0;
	bit held = 1'b0;
	bit moved = 1'b0;

	xml_sax_tokenizer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_in    (char_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.token_kind (token_kind),
		.token_byte (token_byte),
		.last_of_run(last_of_run)
	);

	always #6 clk = ~clk;

	// Rising edge: note accepted requests on both channels, run the watchdog.
	// On the output side only owed tokens count as progress, so a runaway output cannot hang the run.
	always @(posedge clk) begin
		if (arst_n) begin
			moved = (in_valid && in_ready === 1'b1) ||
				(out_valid === 1'b1 && out_ready && sb.owed_tokens.size() != 0);
			if (out_valid === 1'b1 && out_ready)
				sb.check_token(token_kind, token_byte, last_of_run);
			if (in_valid && in_ready === 1'b1)
				sb.note_byte(char_in);
			if (moved)
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Consumer: drops out_ready in random bursts, with stall-free stretches.
	always @(negedge clk) begin
		if (stall_left == 0 && !final_stretch && sink_stalls && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 9);
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
		if ($urandom_range(0, 63) == 0)
			sink_stalls = !sink_stalls;
	end

	// Called just after a falling edge; returns just after the falling edge
	// that follows acceptance, so valid is only re-driven in a later step.
	task automatic send_byte(input logic [7:0] ch);
		int gap;
		gap = 0;
		if (!final_stretch && src_gaps && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_in <= ch;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] markup_byte();
		case ($urandom_range(0, 10))
			0:       return CH_LT;
			1:       return CH_GT;
			2:       return CH_BANG;
			3:       return CH_QUES;
			4:       return CH_SLASH;
			5:       return CH_QUOTE;
			6:       return CH_EQ;
			7:       return CH_DASH;
			8:       return CH_SP;
			9:       return CH_TAB;
			default: return CH_NL;
		endcase
	endfunction

	// Text and value content: mostly letters and spaces, now and then anything.
	function automatic logic [7:0] filler_byte();
		case ($urandom_range(0, 15))
			10, 11:  return CH_SP;
			12:      return 8'(8'h30 + $urandom_range(0, 9));
			13:      return 8'($urandom_range(0, 255));
			14:      return markup_byte();
			15:      return 8'(8'h41 + $urandom_range(0, 25));
			default: return 8'(8'h61 + $urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] name_byte();
		if ($urandom_range(0, 15) == 0)
			return 8'($urandom_range(0, 255));
		return 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	// One random piece of a document; most are well formed, a few are noise.
	task automatic send_fragment();
		case ($urandom_range(0, 11))
			0, 1, 2: begin
				repeat ($urandom_range(1, 8)) send_byte(filler_byte());
			end
			3, 4, 5: begin
				send_byte(CH_LT);
				repeat ($urandom_range(1, 4)) send_byte(name_byte());
				repeat ($urandom_range(0, 3)) begin
					send_byte(CH_SP);
					// empty attribute names allowed
					repeat ($urandom_range(0, 3)) send_byte(name_byte());
					send_byte(CH_EQ);
					send_byte(CH_QUOTE);
					repeat ($urandom_range(0, 4)) send_byte(filler_byte());
					send_byte(CH_QUOTE);
				end
				if ($urandom_range(0, 3) == 0)
					send_byte(CH_SLASH);
				send_byte(CH_GT);
			end
			6, 7: begin
				send_byte(CH_LT);
				send_byte(CH_SLASH);
				repeat ($urandom_range(1, 4)) send_byte(name_byte());
				send_byte(CH_GT);
			end
			8: begin
				send_text("<!--");
				repeat ($urandom_range(0, 6)) send_byte(filler_byte());
				send_text("-->");
			end
			9: begin
				send_text("<?");
				repeat ($urandom_range(1, 5)) send_byte(name_byte());
				send_text("?>");
			end
			10: begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1) == 0)
						send_byte(8'($urandom_range(0, 255)));
					else
						send_byte(markup_byte());
				end
			end
			default: begin
				repeat ($urandom_range(1, 5)) begin
					case ($urandom_range(0, 2))
						0:       send_byte(CH_SP);
						1:       send_byte(CH_TAB);
						default: send_byte(CH_NL);
					endcase
				end
			end
		endcase
	endtask

	// Sender holds off until every owed token has been taken.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (sb.owed_tokens.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a zero byte before any text, a tag with a quoted attribute
		// holding 0xFF, a space kept after a tab and one collapsed after a newline,
		// '!' as plain text, text end before '<', a comment with a slash and dashes,
		// a declaration, a doubled slash before '>' and a stray "/>" in text.
		send_byte(8'h00);
		send_text("<a b=\"");
		send_byte(8'hFF);
		send_text("\"> \t \n !<!-c/-><?x><//>/>");

		// Random documents, with one full drain part-way through.
		while (sent_count < 750) begin
			send_fragment();
			if (!held && sent_count >= 400) begin
				hold_until_drained();
				held = 1'b1;
			end
			if ($urandom_range(0, 7) == 0)
				src_gaps = !src_gaps;
		end

		// Last stretch: no gaps, no stalls.
		final_stretch = 1'b1;
		while (sent_count < 850)
			send_fragment();

		in_valid <= 1'b0;
		while (sb.owed_tokens.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (sb.errors == 0 && sb.owed_tokens.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
rtl/core/xst_pkg.sv
rtl/core/xst_step.sv
rtl/core/xst_tok_fifo.sv
rtl/core/xml_sax_tokenizer.sv
tb/xml_sax_tokenizer_tb.sv
